// File: src/asqrt_pkg.sv
// Shared widths and defaults for the approximate square root core.
`default_nettype none
package asqrt_pkg;

   localparam int DEF_INPUT_BITS = 16;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int TOL_RESET      = 327680;
   localparam int PCT_SCALE      = 100;

endpackage
`default_nettype wire

// File: src/asqrt_root_cell.sv
// One restoring square root step: takes the next radicand pair, passes root and remainder on.
`default_nettype none
module asqrt_root_cell #(
   parameter int RW = 9,
   parameter int MW = 10
) (
   input  wire logic          clock,
   input  wire logic          step_en,
   input  wire logic [1:0]    pair_i,
   input  wire logic [RW-1:0] root_i,
   input  wire logic [MW-1:0] rem_i,
   output logic      [RW-1:0] root_ff,
   output logic      [MW-1:0] rem_ff
);
   logic [MW+1:0] rem_sh;
   logic [MW+1:0] trial;
   logic [RW-1:0] root_in;
   logic [MW-1:0] rem_in;

   // trial subtract of 4*root+1 from the shifted remainder
   always_comb begin
      rem_sh = {rem_i, pair_i};
      trial  = {{(MW-RW){1'b0}}, root_i, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = MW'(rem_sh - trial);
         root_in = {root_i[RW-2:0], 1'b1};
      end else begin
         rem_in  = MW'(rem_sh);
         root_in = {root_i[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end
endmodule
`default_nettype wire

// File: src/asqrt_div_cell.sv
// One restoring division step: shifts in a dividend bit and emits one quotient bit.
`default_nettype none
module asqrt_div_cell #(
   parameter int DW = 24,
   parameter int QW = 40,
   parameter int NW = 40
) (
   input  wire logic          clock,
   input  wire logic          step_en,
   input  wire logic [DW-1:0] den_i,
   input  wire logic [DW-1:0] rem_i,
   input  wire logic [NW-1:0] num_i,
   input  wire logic [QW-1:0] quo_i,
   output logic      [DW-1:0] den_ff,
   output logic      [DW-1:0] rem_ff,
   output logic      [NW-1:0] num_ff,
   output logic      [QW-1:0] quo_ff
);
   logic [DW:0]   rem_sh;
   logic [DW-1:0] rem_in;
   logic          qbit;

   // compare shifted remainder against divisor
   always_comb begin
      rem_sh = {rem_i, num_i[NW-1]};
      qbit   = (rem_sh >= {1'b0, den_i});
      rem_in = qbit ? DW'(rem_sh - {1'b0, den_i}) : DW'(rem_sh);
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         den_ff <= den_i;
         rem_ff <= rem_in;
         num_ff <= {num_i[NW-2:0], 1'b0};
         quo_ff <= {quo_i[QW-2:0], qbit};
      end
   end
endmodule
`default_nettype wire

// File: src/approx_sqrt_with_error_check_core.sv
// Top level: pipelined root, approximation divide and percent deviation check.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata: number
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: approx, exact, deviation, flag
// csr      in   csr_we                 csr_wdata: tolerance_pct
//
// One item per cycle while rsp is not stalled; HALF+FRAC root cells, one operand register,
// HALF+FRAC+1 approx divide cells, one difference register, 2*FRAC+9 deviation
// divide cells and the output register.
// The whole pipeline advances when the output register is free or taken, so a
// stall on rsp holds every stage. Reset clears only valid bits and loads the default tolerance.
`default_nettype none
module approx_sqrt_with_error_check_core #(
   parameter int INPUT_BITS = asqrt_pkg::DEF_INPUT_BITS,
   parameter int FRAC_BITS  = asqrt_pkg::DEF_FRAC_BITS,
   localparam int HALF      = (INPUT_BITS + 1) / 2,
   localparam int AW        = HALF + 1 + FRAC_BITS,
   localparam int EW        = HALF + FRAC_BITS,
   localparam int DEVW      = FRAC_BITS + 7,
   localparam int OUTW      = AW + EW + DEVW + 1,
   localparam int OUTB      = ((OUTW + 7) / 8) * 8,
   localparam int INB       = ((INPUT_BITS + 7) / 8) * 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [INB-1:0]  req_tdata,   // number
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output logic      [OUTB-1:0] rsp_tdata,   // approx_root, exact_root, deviation_pct, over_tolerance
   input  wire logic            csr_we,
   input  wire logic [DEVW-1:0] csr_wdata    // tolerance_pct
);
   import asqrt_pkg::*;

   localparam int RSTEPS = HALF + FRAC_BITS;
   localparam int RW     = EW + 1;
   localparam int MW     = EW + 2;
   // approx divide: (d<<F) / (2r); d <= 2r so quotient < 2^(F+1)
   localparam int ANW    = HALF + 1 + FRAC_BITS;
   localparam int ADW    = HALF + 2;
   // deviation divide: (diff*100)<<F / E; a diff above 2^(F+1) saturates the deviation
   localparam int DNW    = FRAC_BITS + 2 + 7 + FRAC_BITS;
   localparam int DDW    = EW + 1;
   localparam int DMAX   = PCT_SCALE << FRAC_BITS;
   localparam int PW     = FRAC_BITS + 9;

   logic adv;
   logic [DEVW-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= DEVW'(TOL_RESET);
      else if (csr_we) tol_ff <= csr_wdata;
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- root chain ----------------
   logic [RW-1:0]         rroot [0:RSTEPS];
   logic [MW-1:0]         rrem  [0:RSTEPS];
   logic [INPUT_BITS-1:0] rnum  [0:RSTEPS];
   logic [RSTEPS:0]       rval;
   logic [RW-1:0]         rint  [0:RSTEPS];
   logic [MW-1:0]         dint  [0:RSTEPS];

   assign rroot[0] = '0;
   assign rrem[0]  = '0;
   assign rnum[0]  = req_tdata[INPUT_BITS-1:0];
   assign rval[0]  = req_tvalid;
   assign rint[0]  = '0;
   assign dint[0]  = '0;

   for (genvar k = 0; k < RSTEPS; k++) begin : g_root
      logic [1:0] pr;
      logic [INPUT_BITS-1:0] n_ff;
      logic v_ff;
      if (k < HALF) begin : g_int
         logic [2*HALF-1:0] nf;
         assign nf = (2*HALF)'(rnum[k]);
         assign pr = nf[2*(HALF-1-k) +: 2];
      end else begin : g_frac
         assign pr = 2'b00;
      end
      asqrt_root_cell #(.RW(RW), .MW(MW)) u_cell (
         .clock(clock), .step_en(adv), .pair_i(pr),
         .root_i(rroot[k]), .rem_i(rrem[k]),
         .root_ff(rroot[k+1]), .rem_ff(rrem[k+1]));
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= rval[k];
         if (adv) n_ff <= rnum[k];
      end
      // integer root/rem taken right after the last integer cell
      if (k == HALF - 1) begin : g_cap
         assign rint[k+1] = rroot[k+1];
         assign dint[k+1] = rrem[k+1];
      end else begin : g_pass
         logic [RW-1:0] ri_ff;
         logic [MW-1:0] di_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               ri_ff <= rint[k];
               di_ff <= dint[k];
            end
         end
         assign rint[k+1] = ri_ff;
         assign dint[k+1] = di_ff;
      end
      assign rnum[k+1] = n_ff;
      assign rval[k+1] = v_ff;
   end

   // stage A: set up approx divide operands
   logic            a_v_ff, a_z_ff;
   logic [ADW-1:0]  a_den_ff;
   logic [ANW-1:0]  a_num_ff;
   logic [EW-1:0]   a_e_ff;
   logic [HALF-1:0] a_r_ff;

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= rval[RSTEPS];
      if (adv) begin
         a_z_ff   <= (rnum[RSTEPS] == '0);
         a_den_ff <= ADW'({rint[RSTEPS], 1'b0});
         a_num_ff <= ANW'({dint[RSTEPS], {FRAC_BITS{1'b0}}});
         a_e_ff   <= EW'(rroot[RSTEPS]);
         a_r_ff   <= HALF'(rint[RSTEPS]);
      end
   end

   // approx divide chain
   localparam int AQ = ANW;
   logic [ADW-1:0]  ad_den [0:ANW];
   logic [ADW-1:0]  ad_rem [0:ANW];
   logic [ANW-1:0]  ad_num [0:ANW];
   logic [AQ-1:0]   ad_quo [0:ANW];
   logic [ANW:0]    ad_v, ad_z;
   logic [EW-1:0]   ad_e [0:ANW];
   logic [HALF-1:0] ad_r [0:ANW];

   assign ad_den[0] = a_den_ff;
   assign ad_rem[0] = '0;
   assign ad_num[0] = a_num_ff;
   assign ad_quo[0] = '0;
   assign ad_v[0]   = a_v_ff;
   assign ad_z[0]   = a_z_ff;
   assign ad_e[0]   = a_e_ff;
   assign ad_r[0]   = a_r_ff;

   for (genvar k = 0; k < ANW; k++) begin : g_adiv
      logic v_ff, z_ff;
      logic [EW-1:0] e_ff;
      logic [HALF-1:0] r_ff;
      asqrt_div_cell #(.DW(ADW), .QW(AQ), .NW(ANW)) u_cell (
         .clock(clock), .step_en(adv),
         .den_i(ad_den[k]), .rem_i(ad_rem[k]), .num_i(ad_num[k]), .quo_i(ad_quo[k]),
         .den_ff(ad_den[k+1]), .rem_ff(ad_rem[k+1]),
         .num_ff(ad_num[k+1]), .quo_ff(ad_quo[k+1]));
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= ad_v[k];
         if (adv) begin
            z_ff <= ad_z[k];
            e_ff <= ad_e[k];
            r_ff <= ad_r[k];
         end
      end
      assign ad_v[k+1] = v_ff;
      assign ad_z[k+1] = z_ff;
      assign ad_e[k+1] = e_ff;
      assign ad_r[k+1] = r_ff;
   end

   // stage B: approx and |approx - exact|, deviation operands
   logic            b_v_ff, b_z_ff, b_sat_ff;
   logic [AW-1:0]   b_ap_ff;
   logic [EW-1:0]   b_e_ff;
   logic [DNW-1:0]  b_num_ff;
   logic [AW-1:0]   ap_c, df_c;
   logic [PW-1:0]   pct_c;

   always_comb begin
      ap_c  = AW'({ad_r[ANW], {FRAC_BITS{1'b0}}}) + AW'(ad_quo[ANW]);
      df_c  = (ap_c >= AW'(ad_e[ANW])) ? ap_c - AW'(ad_e[ANW]) : AW'(ad_e[ANW]) - ap_c;
      pct_c = PW'(df_c[FRAC_BITS+1:0]) * PW'(PCT_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= ad_v[ANW];
      if (adv) begin
         b_z_ff   <= ad_z[ANW];
         b_ap_ff  <= ap_c;
         b_e_ff   <= ad_e[ANW];
         b_sat_ff <= ((AW+1)'(df_c) > ((AW+1)'(1) << (FRAC_BITS + 1)));
         b_num_ff <= DNW'({pct_c, {FRAC_BITS{1'b0}}});
      end
   end

   // deviation divide chain
   logic [DDW-1:0] dd_den [0:DNW];
   logic [DDW-1:0] dd_rem [0:DNW];
   logic [DNW-1:0] dd_num [0:DNW];
   logic [DNW-1:0] dd_quo [0:DNW];
   logic [DNW:0]   dd_v, dd_z, dd_s;
   logic [AW-1:0]  dd_ap [0:DNW];

   assign dd_den[0] = DDW'(b_e_ff);
   assign dd_rem[0] = '0;
   assign dd_num[0] = b_num_ff;
   assign dd_quo[0] = '0;
   assign dd_v[0]   = b_v_ff;
   assign dd_z[0]   = b_z_ff;
   assign dd_s[0]   = b_sat_ff;
   assign dd_ap[0]  = b_ap_ff;

   for (genvar k = 0; k < DNW; k++) begin : g_ddiv
      logic v_ff, z_ff, s_ff;
      logic [AW-1:0] ap_ff;
      asqrt_div_cell #(.DW(DDW), .QW(DNW), .NW(DNW)) u_cell (
         .clock(clock), .step_en(adv),
         .den_i(dd_den[k]), .rem_i(dd_rem[k]), .num_i(dd_num[k]), .quo_i(dd_quo[k]),
         .den_ff(dd_den[k+1]), .rem_ff(dd_rem[k+1]),
         .num_ff(dd_num[k+1]), .quo_ff(dd_quo[k+1]));
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= dd_v[k];
         if (adv) begin
            z_ff  <= dd_z[k];
            s_ff  <= dd_s[k];
            ap_ff <= dd_ap[k];
         end
      end
      assign dd_v[k+1]  = v_ff;
      assign dd_z[k+1]  = z_ff;
      assign dd_s[k+1]  = s_ff;
      assign dd_ap[k+1] = ap_ff;
   end

   // output register
   logic [DEVW-1:0] dev_c;
   logic [AW-1:0]   o_ap_ff;
   logic [EW-1:0]   o_e_ff;
   logic [DEVW-1:0] o_dev_ff;
   logic            o_flag_ff;

   always_comb begin
      if (dd_s[DNW] || dd_quo[DNW] > DNW'(DMAX)) dev_c = DEVW'(DMAX);
      else dev_c = DEVW'(dd_quo[DNW]);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (adv) rsp_tvalid <= dd_v[DNW];
      if (adv) begin
         o_ap_ff   <= dd_z[DNW] ? '0 : dd_ap[DNW];
         o_e_ff    <= dd_z[DNW] ? '0 : EW'(dd_den[DNW]);
         o_dev_ff  <= dd_z[DNW] ? '0 : dev_c;
         o_flag_ff <= dd_z[DNW] ? 1'b0 : (dev_c > tol_ff);
      end
   end

   assign rsp_tdata = OUTB'({o_flag_ff, o_dev_ff, o_e_ff, o_ap_ff});

   // assertions
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output changed under stall");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready not tied to output slot");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_flag_ff |-> o_dev_ff > tol_ff || $past(csr_we))
      else $error("flag without deviation over tolerance");
endmodule
`default_nettype wire
